// File: rtl/core/rce_pkg.sv
// Shared constants and types of the 3x3 RGB convolution core.
package rce_pkg;
   localparam int MAX_DIM_DEFAULT = 1024;
   localparam int PIX_W = 24;
   localparam int CHAN_W = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 24;
   localparam int SUM_W = 20;
   localparam int DIV_STEPS = SUM_W;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_DIM = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_TOP   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_MID   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_BOT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER    = 3'd5;

   typedef struct packed {
      logic [71:0] kernel;
      logic [7:0]  scale;
      logic        filter;
   } cfg_type;

   typedef struct packed {
      logic        start;
      logic [PIX_W*9-1:0] window;
   } calc_req_type;

   typedef struct packed {
      logic        done;
      logic [PIX_W-1:0] pixel;
   } calc_rsp_type;
endpackage

// File: rtl/core/rce_calc.sv
// Window arithmetic: weighted sums, extremum rejection, division and clamping.
module rce_calc (
   input  logic                   clock,
   input  logic                   reset,
   input  rce_pkg::cfg_type       cfg,
   input  rce_pkg::calc_req_type  req,
   output rce_pkg::calc_rsp_type  rsp
);
   localparam int SW = rce_pkg::SUM_W;
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MAC  = 3'd1;
   localparam logic [2:0] S_SUB  = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [3:0] idx_ff, idx_in;
   logic [4:0] step_ff, step_in;
   logic [1:0] ch_ff, ch_in;
   logic [rce_pkg::PIX_W*9-1:0] win_ff, win_in;
   logic signed [SW-1:0] sum_ff [3];
   logic signed [SW-1:0] sum_in [3];
   logic [9:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [rce_pkg::PIX_W-1:0] lopx_ff, lopx_in, hipx_ff, hipx_in;
   logic [SW-1:0] quo_ff, quo_in;
   logic [8:0] rem_ff, rem_in;
   logic neg_ff, neg_in;
   logic [rce_pkg::PIX_W-1:0] res_ff, res_in;
   logic done_ff, done_in;

   logic [rce_pkg::PIX_W-1:0] px;
   logic signed [7:0] wt;
   logic [9:0] inten;
   logic [7:0] scl;
   logic [8:0] trial;
   logic [SW-1:0] mag;
   logic [SW-1:0] sval;
   logic signed [SW-1:0] sq;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      step_in = step_ff;
      ch_in = ch_ff;
      win_in = win_ff;
      sum_in = sum_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      lopx_in = lopx_ff;
      hipx_in = hipx_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      neg_in = neg_ff;
      res_in = res_ff;
      done_in = 1'b0;
      px = win_ff[idx_ff*rce_pkg::PIX_W +: rce_pkg::PIX_W];
      wt = $signed(cfg.kernel[idx_ff*8 +: 8]);
      inten = {2'b0, px[7:0]} + {2'b0, px[15:8]} + {2'b0, px[23:16]};
      scl = (cfg.scale == 8'd0) ? 8'd1 : cfg.scale;
      sval = sum_ff[ch_ff];
      mag = sval[SW-1] ? SW'(-sval) : sval;
      trial = {rem_ff[7:0], quo_ff[SW-1]};
      sq = neg_ff ? SW'(-$signed(quo_ff)) : $signed(quo_ff);
      case (state_ff)
         S_IDLE: begin
            if (req.start) begin
               win_in = req.window;
               idx_in = 4'd0;
               for (int k = 0; k < 3; k++) sum_in[k] = '0;
               lo_in = 10'd766;
               hi_in = 10'h3FF;
               state_in = S_MAC;
            end
         end
         S_MAC: begin
            for (int k = 0; k < 3; k++)
               sum_in[k] = sum_ff[k] + SW'($signed({1'b0, px[k*8 +: 8]}) * wt);
            if (inten <= lo_ff) begin
               lo_in = inten;
               lopx_in = px;
            end
            if (hi_ff == 10'h3FF || inten > hi_ff) begin
               hi_in = inten;
               hipx_in = px;
            end
            if (idx_ff == 4'd8) state_in = S_SUB;
            else idx_in = idx_ff + 4'd1;
         end
         S_SUB: begin
            if (cfg.filter)
               for (int k = 0; k < 3; k++)
                  sum_in[k] = sum_ff[k] - SW'({1'b0, lopx_ff[k*8 +: 8]})
                              - SW'({1'b0, hipx_ff[k*8 +: 8]});
            ch_in = 2'd0;
            step_in = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (step_ff == 5'd0) begin
               quo_in = mag;
               rem_in = '0;
               neg_in = sval[SW-1];
               step_in = 5'd1;
            end else if (step_ff <= 5'(rce_pkg::DIV_STEPS)) begin
               if (trial >= {1'b0, scl}) begin
                  rem_in = trial - {1'b0, scl};
                  quo_in = {quo_ff[SW-2:0], 1'b1};
               end else begin
                  rem_in = trial;
                  quo_in = {quo_ff[SW-2:0], 1'b0};
               end
               step_in = step_ff + 5'd1;
            end else begin
               res_in[ch_ff*8 +: 8] = (sq < 0) ? 8'd0 :
                  (sq > SW'(255)) ? 8'd255 : sq[7:0];
               step_in = '0;
               if (ch_ff == 2'd2) state_in = S_OUT;
               else ch_in = ch_ff + 2'd1;
            end
         end
         S_OUT: begin
            done_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
      idx_ff <= idx_in;
      step_ff <= step_in;
      ch_ff <= ch_in;
      win_ff <= win_in;
      sum_ff <= sum_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      lopx_ff <= lopx_in;
      hipx_ff <= hipx_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
   end

   assign rsp.done = done_ff;
   assign rsp.pixel = res_ff;
endmodule

// File: rtl/core/rgb_conv3x3_extremum_filter_core.sv
// Top level of the 3x3 RGB convolution core with extremum rejection.
// Pixels enter in raster order, one word per accepted beat, and each word
// leaves zero, one or two result words (interior centre first, then the
// border pixel itself), tlast on the final one. One pixel at a time is in
// flight. Each pixel passes through S_IDLE, S_READ, then S_CALC and S_CTR if it
// completes an interior window, and last S_BRD. An interior window runs the
// nine-step multiply-accumulate and then the bit-serial divider once per colour.
// A new pixel is accepted only once the last result word has been taken. Line
// stores are two 24-bit single-port-per-cycle memories of MAX_DIM words, read
// in the cycle before the write-back; no clearing pass is needed.
module rgb_conv3x3_extremum_filter_core #(
   parameter int MAX_DIM = rce_pkg::MAX_DIM_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // in_red, in_green, in_blue
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // out_red, out_green, out_blue, out_row, out_col, pad
   output logic        rsp_tlast,   // last_of_run
   input  logic        csr_we,
   input  logic [rce_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rce_pkg::CSR_DATA_W-1:0] csr_wdata
);
   localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DW = $clog2(MAX_DIM + 1);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_CALC = 3'd2;
   localparam logic [2:0] S_CTR  = 3'd3;
   localparam logic [2:0] S_BRD  = 3'd4;

   logic [10:0] dim_ff;
   rce_pkg::cfg_type cfg_ff;
   logic [2:0] state_ff, state_in;
   logic [DW-1:0] row_ff, row_in, col_ff, col_in;
   logic [23:0] px_ff, px_in;
   logic [23:0] win_ff [9];
   logic [23:0] win_in [9];
   logic border_ff, border_in;
   logic ovalid_ff, ovalid_in, olast_ff, olast_in;
   logic [47:0] odata_ff, odata_in;
   logic [23:0] up_mem [MAX_DIM];
   logic [23:0] lw_mem [MAX_DIM];
   logic [23:0] up_rd_ff, lw_rd_ff;
   logic mem_we;
   rce_pkg::calc_req_type creq;
   rce_pkg::calc_rsp_type crsp;
   logic [DW-1:0] dim;
   logic [DW+1:0] dim_ext;
   logic [AW-1:0] addr;
   logic interior;
   logic [23:0] cpx;

   assign dim_ext = (dim_ff < 11'd3) ? (DW+2)'(3) :
      ({{(DW+2){1'b0}}, dim_ff} > (DW+13)'(MAX_DIM)) ? (DW+2)'(MAX_DIM) : (DW+2)'(dim_ff);
   assign dim = dim_ext[DW-1:0];
   assign addr = col_ff[AW-1:0];
   assign req_tready = (state_ff == S_IDLE) && !ovalid_ff;
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata = odata_ff;
   assign rsp_tlast = olast_ff;

   rce_calc u_calc (.clock(clock), .reset(reset), .cfg(cfg_ff), .req(creq), .rsp(crsp));

   always_comb begin
      for (int k = 0; k < 9; k++) creq.window[k*24 +: 24] = win_in[k];
      creq.start = (state_ff == S_READ) && interior;
   end

   assign interior = (row_ff >= DW'(2)) && (col_ff >= DW'(2));
   assign border_in = (row_ff == '0) || (col_ff == '0) ||
                      ({1'b0, row_ff} + 1'b1 >= {1'b0, dim}) ||
                      ({1'b0, col_ff} + 1'b1 >= {1'b0, dim});
   assign cpx = crsp.pixel;

   always_comb begin
      state_in = state_ff;
      row_in = row_ff;
      col_in = col_ff;
      px_in = px_ff;
      win_in = win_ff;
      ovalid_in = ovalid_ff && !rsp_tready;
      olast_in = olast_ff;
      odata_in = odata_ff;
      mem_we = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               px_in = req_tdata;
               state_in = S_READ;
            end
         end
         S_READ: begin
            for (int r = 0; r < 3; r++) begin
               win_in[r*3] = win_ff[r*3+1];
               win_in[r*3+1] = win_ff[r*3+2];
            end
            win_in[2] = up_rd_ff;
            win_in[5] = lw_rd_ff;
            win_in[8] = px_ff;
            mem_we = 1'b1;
            state_in = interior ? S_CALC : S_BRD;
         end
         S_CALC: begin
            if (crsp.done) state_in = S_CTR;
         end
         S_CTR: begin
            win_in = win_ff;
            if (!ovalid_ff || rsp_tready) begin
               ovalid_in = 1'b1;
               olast_in = !border_ff;
               odata_in = {4'd0, 10'(col_ff - DW'(1)), 10'(row_ff - DW'(1)), cpx};
               state_in = S_BRD;
            end
         end
         S_BRD: begin
            if (!border_ff || !ovalid_ff || rsp_tready) begin
               if (border_ff) begin
                  ovalid_in = 1'b1;
                  olast_in = 1'b1;
                  odata_in = {4'd0, 10'(col_ff), 10'(row_ff), px_ff};
               end
               if ({1'b0, col_ff} + 1'b1 >= {1'b0, dim}) begin
                  col_in = '0;
                  row_in = ({1'b0, row_ff} + 1'b1 >= {1'b0, dim}) ? '0 : row_ff + DW'(1);
               end else begin
                  col_in = col_ff + DW'(1);
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (csr_we && csr_index == rce_pkg::CSR_IMAGE_DIM) begin
         row_in = '0;
         col_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         up_mem[addr] <= lw_rd_ff;
         lw_mem[addr] <= px_ff;
      end
      up_rd_ff <= up_mem[addr];
      lw_rd_ff <= lw_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         row_ff <= '0;
         col_ff <= '0;
         ovalid_ff <= 1'b0;
         dim_ff <= 11'd3;
         cfg_ff.kernel <= {3{24'h010101}};
         cfg_ff.scale <= 8'd9;
         cfg_ff.filter <= 1'b0;
         for (int k = 0; k < 9; k++) win_ff[k] <= '0;
      end else begin
         state_ff <= state_in;
         row_ff <= row_in;
         col_ff <= col_in;
         ovalid_ff <= ovalid_in;
         win_ff <= win_in;
         if (csr_we) begin
            case (csr_index)
               rce_pkg::CSR_IMAGE_DIM: dim_ff <= csr_wdata[10:0];
               rce_pkg::CSR_ROW_TOP:   cfg_ff.kernel[23:0] <= csr_wdata;
               rce_pkg::CSR_ROW_MID:   cfg_ff.kernel[47:24] <= csr_wdata;
               rce_pkg::CSR_ROW_BOT:   cfg_ff.kernel[71:48] <= csr_wdata;
               rce_pkg::CSR_SCALE:     cfg_ff.scale <= csr_wdata[7:0];
               rce_pkg::CSR_FILTER:    cfg_ff.filter <= csr_wdata[0];
               default: ;
            endcase
         end
      end
      px_ff <= px_in;
      olast_ff <= olast_in;
      odata_ff <= odata_in;
      if (state_ff == S_READ) border_ff <= border_in;
   end
endmodule

// File: tb/sv/rgb_conv3x3_extremum_filter_core_tb.sv
// Self-checking testbench of the 3x3 RGB convolution core with extremum rejection.
module rgb_conv3x3_extremum_filter_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIM_MAX = 1024;
   localparam int SETTLE = 200;
   localparam int CYCLE_LIMIT = 3000000;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [9:0] row;
      logic [9:0] col;
      logic       last;
   } pixel_out_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [rce_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [rce_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   rgb_conv3x3_extremum_filter_core i_dut (.*);

   always #4 clock = ~clock;

   // predictor state
   logic [10:0] cfg_dim;
   logic [23:0] cfg_krow [3];
   logic [7:0]  cfg_scale;
   logic        cfg_filter;
   logic [23:0] row_above2 [DIM_MAX];
   logic [23:0] row_above1 [DIM_MAX];
   logic [23:0] win [3][3];
   int          next_row, next_col;

   pixel_out_type pending_pixels[$];
   int          errors = 0;
   int          cycles = 0;
   bit          quiet = 1'b0;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // result side back-pressure
   int stall_left = 0;
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_tready <= !reset;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 9);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      pixel_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t unexpected word: actual %h last %b", $realtime, rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_tdata[7:0] !== want.red || rsp_tdata[15:8] !== want.green ||
                rsp_tdata[23:16] !== want.blue || rsp_tdata[33:24] !== want.row ||
                rsp_tdata[43:34] !== want.col || rsp_tlast !== want.last) begin
               $display("%0t mismatch: expected rgb %h %h %h at (%0d,%0d) last %b",
                        $realtime, want.red, want.green, want.blue, want.row, want.col,
                        want.last);
               $display("%0t            actual rgb %h %h %h at (%0d,%0d) last %b",
                        $realtime, rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16],
                        rsp_tdata[33:24], rsp_tdata[43:34], rsp_tlast);
               errors++;
            end
         end
      end
   end

   function automatic int dim_used();
      if (cfg_dim < 3) return 3;
      if (cfg_dim > DIM_MAX) return DIM_MAX;
      return int'(cfg_dim);
   endfunction

   function automatic int brightness(logic [23:0] px);
      return int'(px[7:0]) + int'(px[15:8]) + int'(px[23:16]);
   endfunction

   function automatic logic [23:0] filtered_centre();
      int acc [3];
      int lo, hi, w, q, den;
      logic [23:0] lo_px, hi_px, res;
      acc = '{0, 0, 0};
      lo = 766;
      hi = -1;
      lo_px = '0;
      hi_px = '0;
      den = (cfg_scale == 0) ? 1 : int'(cfg_scale);
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            w = int'($signed(cfg_krow[r][8*c +: 8]));
            for (int ch = 0; ch < 3; ch++) acc[ch] += int'(win[r][c][8*ch +: 8]) * w;
            if (brightness(win[r][c]) <= lo) begin
               lo = brightness(win[r][c]);
               lo_px = win[r][c];
            end
            if (brightness(win[r][c]) > hi) begin
               hi = brightness(win[r][c]);
               hi_px = win[r][c];
            end
         end
      end
      for (int ch = 0; ch < 3; ch++) begin
         if (cfg_filter) acc[ch] -= int'(lo_px[8*ch +: 8]) + int'(hi_px[8*ch +: 8]);
         q = acc[ch] / den;
         if (q < 0) q = 0;
         if (q > 255) q = 255;
         res[8*ch +: 8] = q[7:0];
      end
      return res;
   endfunction

   function automatic void push_pixel(logic [23:0] px, int row, int col);
      pixel_out_type p;
      p.red = px[7:0];
      p.green = px[15:8];
      p.blue = px[23:16];
      p.row = row[9:0];
      p.col = col[9:0];
      p.last = 1'b0;
      pending_pixels.push_back(p);
   endfunction

   function automatic void predict_pixel(logic [23:0] px);
      int d, r, c, n0;
      d = dim_used();
      r = next_row;
      c = next_col;
      n0 = pending_pixels.size();
      for (int i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = row_above2[c];
      win[1][2] = row_above1[c];
      win[2][2] = px;
      row_above2[c] = row_above1[c];
      row_above1[c] = px;
      if (r >= 2 && c >= 2) push_pixel(filtered_centre(), r - 1, c - 1);
      if (r == 0 || c == 0 || r + 1 >= d || c + 1 >= d) push_pixel(px, r, c);
      if (pending_pixels.size() > n0) pending_pixels[pending_pixels.size() - 1].last = 1'b1;
      if (c + 1 >= d) begin
         next_col = 0;
         next_row = (r + 1 >= d) ? 0 : r + 1;
      end else begin
         next_col = c + 1;
      end
   endfunction

   task automatic send_pixel(logic [23:0] px);
      req_tvalid <= 1'b1;
      req_tdata <= px;
      do @(posedge clock); while (!req_tready);
      predict_pixel(px);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [rce_pkg::CSR_IDX_W-1:0] idx,
                            logic [rce_pkg::CSR_DATA_W-1:0] val);
      wait_drained();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         rce_pkg::CSR_IMAGE_DIM: begin
            cfg_dim = val[10:0];
            next_row = 0;
            next_col = 0;
         end
         rce_pkg::CSR_ROW_TOP: cfg_krow[0] = val;
         rce_pkg::CSR_ROW_MID: cfg_krow[1] = val;
         rce_pkg::CSR_ROW_BOT: cfg_krow[2] = val;
         rce_pkg::CSR_SCALE:   cfg_scale = val[7:0];
         rce_pkg::CSR_FILTER:  cfg_filter = val[0];
         default: ;
      endcase
   endtask

   task automatic send_frame(int n);
      for (int i = 0; i < n; i++) send_pixel(24'($urandom()));
   endtask

   task automatic test_reset_defaults();
      send_pixel(24'h000000);
      send_pixel(24'hFFFFFF);
      send_pixel(24'h000000);
      send_pixel(24'hFFFFFF);
      send_pixel(24'hFFFFFF);
      send_pixel(24'hFFFFFF);
      send_pixel(24'h00FF00);
      send_pixel(24'hFF00FF);
      send_pixel(24'h0000FF);
   endtask

   task automatic test_extreme_weights();
      write_reg(rce_pkg::CSR_IMAGE_DIM, 24'd2);
      write_reg(rce_pkg::CSR_ROW_TOP, 24'h80807F);
      write_reg(rce_pkg::CSR_ROW_MID, 24'h7F7F7F);
      write_reg(rce_pkg::CSR_ROW_BOT, 24'hFF8001);
      write_reg(rce_pkg::CSR_SCALE, 24'd0);
      write_reg(rce_pkg::CSR_FILTER, 24'd1);
      for (int i = 0; i < 9; i++) send_pixel((i % 2) ? 24'hFFFFFF : 24'h010203);
      write_reg(rce_pkg::CSR_SCALE, 24'd255);
      write_reg(rce_pkg::CSR_ROW_TOP, 24'h010101);
      write_reg(rce_pkg::CSR_ROW_MID, 24'h010101);
      write_reg(rce_pkg::CSR_ROW_BOT, 24'h010101);
      for (int i = 0; i < 9; i++) send_pixel(24'h808080);
   endtask

   task automatic test_full_width();
      write_reg(rce_pkg::CSR_SCALE, 24'd1);
      write_reg(rce_pkg::CSR_IMAGE_DIM, 24'h7FF);
      send_frame(24);
      write_reg(rce_pkg::CSR_IMAGE_DIM, 24'd0);
      send_frame(9);
   endtask

   task automatic test_random_frames();
      int d, total;
      total = 0;
      while (total < 440) begin
         write_reg(rce_pkg::CSR_ROW_TOP, 24'($urandom()));
         write_reg(rce_pkg::CSR_ROW_MID, ($urandom_range(0, 1)) ? 24'($urandom()) : 24'h020402);
         write_reg(rce_pkg::CSR_ROW_BOT, 24'($urandom()));
         write_reg(rce_pkg::CSR_SCALE, 24'($urandom_range(0, 255)));
         write_reg(rce_pkg::CSR_FILTER, 24'($urandom_range(0, 1)));
         d = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(3, 8);
         write_reg(rce_pkg::CSR_IMAGE_DIM, 24'(d));
         if (total > 320) quiet = 1'b1;
         send_frame(d * d + (($urandom_range(0, 3) == 0) ? $urandom_range(1, d) : 0));
         total += d * d;
      end
   endtask

   task automatic test_sender_pause();
      write_reg(rce_pkg::CSR_IMAGE_DIM, 24'd5);
      send_frame(12);
      wait_drained();
      send_frame(13);
   endtask

   initial begin
      cfg_dim = 11'd3;
      cfg_krow = '{24'h010101, 24'h010101, 24'h010101};
      cfg_scale = 8'd9;
      cfg_filter = 1'b0;
      for (int i = 0; i < DIM_MAX; i++) begin
         row_above2[i] = '0;
         row_above1[i] = '0;
      end
      win = '{default: '0};
      next_row = 0;
      next_col = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_extreme_weights();
      test_full_width();
      test_sender_pause();
      test_random_frames();
      wait_drained();
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
